### rtl/core/orbrr_pkg.sv
// Package for the overwriting ring buffer with range read.
// Holds the controller state type, status codes and fixed field widths.
// No dependencies.
package orbrr_pkg;

  localparam int unsigned DATA_W   = 64;
  localparam int unsigned OFFSET_W = 6;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned STATUS_W = 2;

  localparam logic KIND_ENQUEUE = 1'b0;
  localparam logic KIND_RANGE   = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_ELEMENT = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_STREAM
  } state_e;

endpackage

### rtl/core/orbrr_store.sv
// Sample store of the ring buffer: one write port, one read port.
// Read data is registered and holds its value until the next read.
// No dependencies.
module orbrr_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 64,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/overwrite_ring_buffer_range_read.sv
// Top level of the overwriting ring buffer with range read.
// Depends on orbrr_pkg and orbrr_store.
//
//   Channel | Handshake                 | Payload
//   --------+---------------------------+------------------------------------------
//   in      | in_valid_i / in_stall_o   | kind_i, sample_i, start_offset_i, count_i
//   out     | out_valid_o / out_stall_i | element_data_o, status_o, last_flag_o
//
// An enqueue beat is taken every cycle while idle and writes the store straight away.
// A range beat is bounds-checked in S_CHECK; a refused or empty range then gives one
// beat and frees the input once the output register is free.
// Otherwise one sample a cycle is read through the registered store port while the output is
// not stalled; input stays stalled until the last sample is in the output register and the FSM is idle again.
// Reset clears the pointers, state, rem, pend and output valid. A stalled output holds its beat and halts the reads.
module overwrite_ring_buffer_range_read #(
  parameter int unsigned QUEUE_DEPTH  = 64,
  parameter int unsigned SAMPLE_WIDTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   kind_i,
  input  logic [orbrr_pkg::DATA_W-1:0]           sample_i,
  input  logic [orbrr_pkg::OFFSET_W-1:0]         start_offset_i,
  input  logic [orbrr_pkg::COUNT_W-1:0]          count_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [orbrr_pkg::DATA_W-1:0]           element_data_o,
  output logic [orbrr_pkg::STATUS_W-1:0]         status_o,
  output logic                                   last_flag_o
);

  import orbrr_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [OFFSET_W:0] DepthExt = (OFFSET_W + 1)'(QUEUE_DEPTH);

  state_e state_q, state_d;

  logic [PtrW-1:0]     wp_q, wp_d, rp_q, rp_d;
  logic [PtrW-1:0]     addr_q, addr_d;
  logic [COUNT_W-1:0]  rem_q, rem_d;
  logic [OFFSET_W-1:0] start_q;
  logic [COUNT_W-1:0]  count_q;
  logic                pend_q, pend_d;
  logic                rd_last_q;

  logic                    out_valid_q;
  logic [DATA_W-1:0]       out_data_q;
  logic [STATUS_W-1:0]     out_status_q;
  logic                    out_last_q;

  logic                    in_accept;
  logic                    enq;
  logic                    range_acc;
  logic [PtrW-1:0]         wp_next;
  logic [PtrW-1:0]         held;
  logic [OFFSET_W:0]       req_end;
  logic [OFFSET_W:0]       first_sum;
  logic [PtrW-1:0]         first_addr;
  logic                    refused;
  logic                    empty;
  logic                    out_free;
  logic                    issue;
  logic                    move;
  logic                    load_single;
  logic [SAMPLE_WIDTH-1:0] rd_data;

  assign in_accept = in_valid_i && !in_stall_o;
  assign enq       = in_accept && (kind_i == KIND_ENQUEUE);
  assign range_acc = in_accept && (kind_i == KIND_RANGE);
  assign wp_next   = (wp_q == LastPtr) ? '0 : wp_q + 1'b1;

  assign held      = (wp_q >= rp_q) ? wp_q - rp_q : PtrW'(QUEUE_DEPTH - 32'(rp_q) + 32'(wp_q));
  assign req_end   = {1'b0, start_q} + {1'b0, count_q};
  assign refused   = req_end > (OFFSET_W + 1)'(held);
  assign empty     = (count_q == '0);
  assign first_sum = {1'b0, start_q} + (OFFSET_W + 1)'(rp_q);
  assign first_addr = (first_sum >= DepthExt) ? PtrW'(first_sum - DepthExt)
                                              : PtrW'(first_sum);

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (range_acc) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!(refused || empty)) begin
          state_d = S_STREAM;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_STREAM: begin
        if ((rem_q == '0) && !pend_q) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    issue       = 1'b0;
    move        = 1'b0;
    load_single = 1'b0;
    wp_d        = wp_q;
    rp_d        = rp_q;
    addr_d      = addr_q;
    rem_d       = rem_q;
    pend_d      = pend_q;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (enq) begin
          wp_d = wp_next;
          if (wp_next == rp_q) begin
            rp_d = (rp_q == LastPtr) ? '0 : rp_q + 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (refused || empty) begin
          load_single = out_free;
        end else begin
          addr_d = first_addr;
          rem_d  = count_q;
        end
      end
      S_STREAM: begin
        move  = pend_q && out_free;
        issue = (rem_q != '0) && (!pend_q || move);
        if (issue) begin
          addr_d = (addr_q == LastPtr) ? '0 : addr_q + 1'b1;
          rem_d  = rem_q - 1'b1;
          pend_d = 1'b1;
        end else if (move) begin
          pend_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  orbrr_store #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(SAMPLE_WIDTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (enq),
    .wr_addr_i (wp_q),
    .wr_data_i (sample_i[SAMPLE_WIDTH-1:0]),
    .rd_en_i   (issue),
    .rd_addr_i (addr_q),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      rem_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      rem_q   <= rem_d;
      pend_q  <= pend_d;
      if (load_single || move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    if (range_acc) begin
      start_q <= start_offset_i;
      count_q <= count_i;
    end
    if (issue) begin
      rd_last_q <= (rem_q == COUNT_W'(1));
    end
    if (load_single) begin
      out_data_q   <= '0;
      out_status_q <= refused ? STATUS_REFUSED : STATUS_EMPTY;
      out_last_q   <= 1'b1;
    end else if (move) begin
      out_data_q   <= DATA_W'(rd_data);
      out_status_q <= STATUS_ELEMENT;
      out_last_q   <= rd_last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign element_data_o = out_data_q;
  assign status_o       = out_status_q;
  assign last_flag_o    = out_last_q;

  a_no_rw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(enq && issue))
    else $error("Store written and read in the same cycle.");

  a_not_empty_after_enq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq |=> (wp_q != rp_q))
    else $error("Buffer reads as empty straight after an enqueue.");

  a_ptr_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(wp_q) < QUEUE_DEPTH) && (32'(rp_q) < QUEUE_DEPTH))
    else $error("Pointer outside the buffer depth.");

  a_idle_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((rem_q == '0) && !pend_q))
    else $error("Idle with reads still outstanding.");

endmodule
